// ----- hdl/pfa_pkg.sv -----
`default_nettype none
package pfa_pkg;

    localparam int COORD_W = 16;
    localparam int EDGE_W  = 17;
    localparam int MOP_W   = 18;
    localparam int PROD_W  = 36;
    localparam int CROSS_W = 36;
    localparam int SUM_W   = 70;
    localparam int ROOT_W  = 36;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int AREA_W  = 42;
    localparam int TOTAL_W = 9;
    localparam int OP_W    = 4;

    // multiplier schedule: six cross product terms, then three partial squares per component
    localparam logic [OP_W-1:0] OP_CROSS_LAST = OP_W'(5);
    localparam logic [OP_W-1:0] OP_LAST       = OP_W'(14);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_START,
        ST_ROOT,
        ST_ADD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_status;

endpackage
`default_nettype wire

// ----- hdl/pfa_mul.sv -----
`default_nettype none
module pfa_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [pfa_pkg::MOP_W-1:0]   i_a,
    input  wire logic signed [pfa_pkg::MOP_W-1:0]   i_b,
    output logic signed [pfa_pkg::PROD_W-1:0]       o_prod
);

    logic signed [pfa_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ----- hdl/pfa_isqrt.sv -----
`default_nettype none
module pfa_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pfa_pkg::RAD_W-1:0]     i_rad,
    output pfa_pkg::t_root_status              o_status,
    output logic [pfa_pkg::ROOT_W-1:0]         o_root
);

    localparam int CNT_W = $clog2(pfa_pkg::ROOT_W);

    logic [pfa_pkg::RAD_W-1:0]  r_rad;
    logic [pfa_pkg::REM_W-1:0]  r_rem;
    logic [pfa_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [pfa_pkg::REM_W-1:0]  rem_sh;
    logic [pfa_pkg::REM_W-1:0]  trial;
    logic [pfa_pkg::REM_W-1:0]  n_rem;
    logic [pfa_pkg::ROOT_W-1:0] n_root;

    // one result bit per cycle, two radicand bits brought down each step
    always_comb begin
        rem_sh = {r_rem[pfa_pkg::REM_W-3:0], r_rad[pfa_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = rem_sh - trial;
            n_root = {r_root[pfa_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh;
            n_root = {r_root[pfa_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[pfa_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(pfa_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_root        = r_root;

endmodule
`default_nettype wire

// ----- hdl/polygon_fan_area_accumulator.sv -----
// Polygon area accumulator: vertices of one 3D polygon arrive one per request
// (signed Q12.4), the final one flagged by i_last. From the third vertex on, the
// magnitude of the fan triangle's cross product (twice its area) is added to a
// saturating 42-bit sum; on the final vertex the area (9 fraction bits), the
// vertex count and an overflow flag are presented. A first or second vertex,
// or a vertex beyond MAX_VERTS, goes from its accepting cycle straight to the
// finishing step. A vertex that forms a triangle passes the accepting cycle,
// 15 operations through one shared 18x18 multiplier (cross product, then squares
// from partial products), the step that starts the root, a bit-serial square
// root and its done cycle, one step to add and one to finish. The block takes
// no new vertex meanwhile. A result waiting on i_stall holds the block only when
// the next polygon's final vertex reaches its finishing step; until then vertices
// are taken as usual.
`default_nettype none
module polygon_fan_area_accumulator #(
    parameter int MAX_VERTS = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [pfa_pkg::COORD_W-1:0]   i_vx,
    input  wire logic signed [pfa_pkg::COORD_W-1:0]   i_vy,
    input  wire logic signed [pfa_pkg::COORD_W-1:0]   i_vz,
    input  wire logic                                 i_last,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [pfa_pkg::AREA_W-1:0]                o_area,
    output logic [pfa_pkg::TOTAL_W-1:0]               o_vertex_total,
    output logic                                      o_overflow
);

    localparam int CW = $clog2(MAX_VERTS + 1);

    pfa_pkg::t_state r_state, n_state;

    logic signed [pfa_pkg::COORD_W-1:0] r_fan  [3];
    logic signed [pfa_pkg::COORD_W-1:0] r_prev [3];
    logic signed [pfa_pkg::COORD_W-1:0] r_cur  [3];
    logic signed [pfa_pkg::CROSS_W-1:0] r_c    [3];
    logic                               r_last;
    logic [CW-1:0]                      r_cnt;
    logic [pfa_pkg::AREA_W-1:0]         r_sum;
    logic                               r_ovf;
    logic [pfa_pkg::OP_W-1:0]           r_op;
    logic [pfa_pkg::SUM_W-1:0]          r_sq;

    logic                               r_o_valid;
    logic [pfa_pkg::AREA_W-1:0]         r_o_area;
    logic [pfa_pkg::TOTAL_W-1:0]        r_o_total;
    logic                               r_o_ovf;

    logic accept, cnt_full, cnt_two, out_blocked;
    logic mul_en, root_start, do_acc, do_add, do_finish;

    logic signed [pfa_pkg::EDGE_W-1:0]  e1 [3];
    logic signed [pfa_pkg::EDGE_W-1:0]  e2 [3];
    logic signed [pfa_pkg::MOP_W-1:0]   op_a, op_b;
    logic signed [pfa_pkg::CROSS_W-1:0] c_sel, c_abs;
    logic [1:0]                         part;
    logic signed [pfa_pkg::PROD_W-1:0]  prod;
    logic [pfa_pkg::SUM_W-1:0]          prod_ext;
    logic [pfa_pkg::AREA_W:0]           sum_wide;
    logic [CW+pfa_pkg::TOTAL_W-1:0]     total_wide;

    pfa_pkg::t_root_status              root_status;
    logic [pfa_pkg::ROOT_W-1:0]         root;

    function automatic logic signed [pfa_pkg::EDGE_W-1:0] EDGE_W_SUB(
        input logic signed [pfa_pkg::COORD_W-1:0] a,
        input logic signed [pfa_pkg::COORD_W-1:0] b
    );
        logic signed [pfa_pkg::EDGE_W-1:0] d;
        d = pfa_pkg::EDGE_W'(a) - pfa_pkg::EDGE_W'(b);
        return d;
    endfunction

    assign accept      = i_valid && (r_state == pfa_pkg::ST_IDLE);
    assign o_stall     = (r_state != pfa_pkg::ST_IDLE);
    assign cnt_full    = (r_cnt >= CW'(MAX_VERTS));
    assign cnt_two     = (r_cnt >= CW'(2));
    assign out_blocked = r_o_valid && i_stall;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = EDGE_W_SUB(r_prev[k], r_fan[k]);
            e2[k] = EDGE_W_SUB(r_cur[k], r_fan[k]);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        c_sel = r_c[0];
        part  = 2'd0;
        case (r_op) inside
            [4'd6:4'd8]:   c_sel = r_c[0];
            [4'd9:4'd11]:  c_sel = r_c[1];
            [4'd12:4'd14]: c_sel = r_c[2];
            default:       c_sel = r_c[0];
        endcase
        case (r_op) inside
            4'd6, 4'd9, 4'd12: part = 2'd0;
            4'd7, 4'd10, 4'd13: part = 2'd1;
            4'd8, 4'd11, 4'd14: part = 2'd2;
            default:            part = 2'd0;
        endcase
        c_abs = (c_sel < 0) ? -c_sel : c_sel;
        op_a  = '0;
        op_b  = '0;
        case (r_op)
            4'd0: begin op_a = pfa_pkg::MOP_W'(e1[1]); op_b = pfa_pkg::MOP_W'(e2[2]); end
            4'd1: begin op_a = pfa_pkg::MOP_W'(e1[2]); op_b = pfa_pkg::MOP_W'(e2[1]); end
            4'd2: begin op_a = pfa_pkg::MOP_W'(e1[2]); op_b = pfa_pkg::MOP_W'(e2[0]); end
            4'd3: begin op_a = pfa_pkg::MOP_W'(e1[0]); op_b = pfa_pkg::MOP_W'(e2[2]); end
            4'd4: begin op_a = pfa_pkg::MOP_W'(e1[0]); op_b = pfa_pkg::MOP_W'(e2[1]); end
            4'd5: begin op_a = pfa_pkg::MOP_W'(e1[1]); op_b = pfa_pkg::MOP_W'(e2[0]); end
            default: begin
                // |c| = hi*2^17 + lo, squared as lo*lo, hi*lo (twice), hi*hi
                case (part)
                    2'd0: begin
                        op_a = {1'b0, c_abs[16:0]};
                        op_b = {1'b0, c_abs[16:0]};
                    end
                    2'd1: begin
                        op_a = {1'b0, c_abs[33:17]};
                        op_b = {1'b0, c_abs[16:0]};
                    end
                    default: begin
                        op_a = {1'b0, c_abs[33:17]};
                        op_b = {1'b0, c_abs[33:17]};
                    end
                endcase
            end
        endcase
    end

    pfa_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    pfa_isqrt u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (root_start),
        .i_rad    (pfa_pkg::RAD_W'(r_sq)),
        .o_status (root_status),
        .o_root   (root)
    );

    assign prod_ext   = pfa_pkg::SUM_W'($unsigned(prod));
    assign sum_wide   = {1'b0, r_sum} + (pfa_pkg::AREA_W + 1)'(root);
    assign total_wide = (CW + pfa_pkg::TOTAL_W)'(r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (!cnt_full && cnt_two) ? pfa_pkg::ST_MUL : pfa_pkg::ST_FINISH;
                end
            end
            pfa_pkg::ST_MUL:   n_state = pfa_pkg::ST_ACC;
            pfa_pkg::ST_ACC: begin
                n_state = (r_op == pfa_pkg::OP_LAST) ? pfa_pkg::ST_START : pfa_pkg::ST_MUL;
            end
            pfa_pkg::ST_START: n_state = pfa_pkg::ST_ROOT;
            pfa_pkg::ST_ROOT: begin
                if (root_status.done) begin
                    n_state = pfa_pkg::ST_ADD;
                end
            end
            pfa_pkg::ST_ADD:   n_state = pfa_pkg::ST_FINISH;
            pfa_pkg::ST_FINISH: begin
                if (!(r_last && out_blocked)) begin
                    n_state = pfa_pkg::ST_IDLE;
                end
            end
            default:           n_state = pfa_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mul_en     = 1'b0;
        do_acc     = 1'b0;
        root_start = 1'b0;
        do_add     = 1'b0;
        do_finish  = 1'b0;
        case (r_state)
            pfa_pkg::ST_MUL:    mul_en     = 1'b1;
            pfa_pkg::ST_ACC:    do_acc     = 1'b1;
            pfa_pkg::ST_START:  root_start = 1'b1;
            pfa_pkg::ST_ROOT:   do_add     = 1'b0;
            pfa_pkg::ST_ADD:    do_add     = 1'b1;
            pfa_pkg::ST_FINISH: do_finish  = r_last && !out_blocked;
            default:            mul_en     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_op    <= '0;
            for (int k = 0; k < 3; k++) begin
                r_fan[k]  <= '0;
                r_prev[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cur[0] <= i_vx;
                r_cur[1] <= i_vy;
                r_cur[2] <= i_vz;
                r_last   <= i_last;
                r_op     <= '0;
                r_sq     <= '0;
                if (cnt_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == '0) begin
                        r_fan[0] <= i_vx;
                        r_fan[1] <= i_vy;
                        r_fan[2] <= i_vz;
                    end
                    // a vertex that forms a triangle replaces prev only after its area is in
                    if (!cnt_two) begin
                        r_prev[0] <= i_vx;
                        r_prev[1] <= i_vy;
                        r_prev[2] <= i_vz;
                    end
                end
            end
            if (do_acc) begin
                r_op <= r_op + pfa_pkg::OP_W'(1);
                if (r_op <= pfa_pkg::OP_CROSS_LAST) begin
                    if (!r_op[0]) begin
                        r_c[r_op[2:1]] <= prod;
                    end else begin
                        r_c[r_op[2:1]] <= r_c[r_op[2:1]] - prod;
                    end
                end else begin
                    case (part)
                        2'd0:    r_sq <= r_sq + prod_ext;
                        2'd1:    r_sq <= r_sq + (prod_ext << 18);
                        default: r_sq <= r_sq + (prod_ext << 34);
                    endcase
                end
            end
            if (do_add) begin
                if (sum_wide[pfa_pkg::AREA_W]) begin
                    r_sum <= '1;
                    r_ovf <= 1'b1;
                end else begin
                    r_sum <= sum_wide[pfa_pkg::AREA_W-1:0];
                end
                r_prev <= r_cur;
            end
            if (do_finish) begin
                r_cnt <= '0;
                r_sum <= '0;
                r_ovf <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_fan[k]  <= '0;
                    r_prev[k] <= '0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (do_finish) begin
                r_o_valid <= 1'b1;
                r_o_area  <= r_sum;
                r_o_total <= total_wide[pfa_pkg::TOTAL_W-1:0];
                r_o_ovf   <= r_ovf;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_area         = r_o_area;
    assign o_vertex_total = r_o_total;
    assign o_overflow     = r_o_ovf;

endmodule
`default_nettype wire

// ----- hdl/pfa_chk.sv -----
`default_nettype none
module pfa_chk #(
    parameter int MAX_VERTS = 256
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic [pfa_pkg::AREA_W-1:0]           o_area,
    input wire logic [pfa_pkg::TOTAL_W-1:0]          o_vertex_total,
    input wire logic                                 o_overflow
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_area) && $stable(o_vertex_total)
            && $stable(o_overflow))
        else $error("result changed while stalled");

    // every vertex request that is taken raises o_stall
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("ready straight after a vertex request");

    // fewer than three vertices cannot give an area
    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_VERTS < 512) && o_valid && (o_vertex_total < 9'd3) |-> (o_area == '0))
        else $error("area from a degenerate polygon");

    // count never passes the limit
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_VERTS < 512) && o_valid |-> (o_vertex_total <= pfa_pkg::TOTAL_W'(MAX_VERTS)))
        else $error("vertex total beyond limit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or busy out of reset");

endmodule

bind polygon_fan_area_accumulator pfa_chk #(.MAX_VERTS(MAX_VERTS)) u_pfa_chk (.*);
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
module tb;

    localparam int                         MAX_VERTS = 256;
    localparam logic [pfa_pkg::AREA_W-1:0] AREA_MAX  = {pfa_pkg::AREA_W{1'b1}};

    typedef struct packed {
        logic [pfa_pkg::AREA_W-1:0]  area;
        logic [pfa_pkg::TOTAL_W-1:0] total;
        logic                        ovf;
    } t_area_result;

    typedef struct {
        logic [pfa_pkg::COORD_W-1:0] x, y, z;
        logic                        last;
        bit                          typed;
        t_area_result                res;
    } t_vertex_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic signed [pfa_pkg::COORD_W-1:0] i_vx = '0, i_vy = '0, i_vz = '0;
    logic                               i_last = 1'b0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [pfa_pkg::AREA_W-1:0]         o_area;
    logic [pfa_pkg::TOTAL_W-1:0]        o_vertex_total;
    logic                               o_overflow;

    // typed expectation travelling with the current request
    bit           req_typed = 1'b0;
    t_area_result req_res = '0;

    polygon_fan_area_accumulator #(.MAX_VERTS(MAX_VERTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_vx(i_vx), .i_vy(i_vy), .i_vz(i_vz), .i_last(i_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_area(o_area), .o_vertex_total(o_vertex_total), .o_overflow(o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // polygon state of the predictor
    logic signed [pfa_pkg::COORD_W-1:0] fan_pt[3], prev_pt[3];
    int                                 vert_cnt;
    logic [pfa_pkg::AREA_W-1:0]         twice_area_sum;
    bit                                 ovf_sticky;

    t_area_result area_q[$];
    t_vertex_row  rows[$];
    int           mismatches = 0;
    bit           quiet = 1'b0;
    bit           long_hold = 1'b0;

    function automatic logic [pfa_pkg::ROOT_W-1:0] root72(logic [71:0] n);
        logic [pfa_pkg::ROOT_W-1:0] r;
        logic [pfa_pkg::ROOT_W-1:0] t;
        r = '0;
        for (int i = pfa_pkg::ROOT_W - 1; i >= 0; i--) begin
            t = r | (pfa_pkg::ROOT_W'(1) << i);
            if ({36'd0, t} * {36'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    function automatic logic [pfa_pkg::ROOT_W-1:0] fan_cross_mag(
        logic signed [pfa_pkg::COORD_W-1:0] p[3]);
        longint    e1[3], e2[3], c[3];
        logic [71:0] s;
        logic [71:0] a;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            e1[k] = longint'(prev_pt[k]) - longint'(fan_pt[k]);
            e2[k] = longint'(p[k]) - longint'(fan_pt[k]);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int k = 0; k < 3; k++) begin
            a = 72'(c[k] < 0 ? -c[k] : c[k]);
            s += a * a;
        end
        return root72(s);
    endfunction

    function automatic void clear_polygon();
        for (int k = 0; k < 3; k++) begin
            fan_pt[k] = '0;
            prev_pt[k] = '0;
        end
        vert_cnt = 0;
        twice_area_sum = '0;
        ovf_sticky = 1'b0;
    endfunction

    // returns 1 when the vertex closes a polygon
    function automatic bit add_vertex(logic signed [pfa_pkg::COORD_W-1:0] p[3], logic lst,
                                      output t_area_result res);
        logic [pfa_pkg::ROOT_W-1:0] mag;
        if (vert_cnt >= MAX_VERTS) begin
            ovf_sticky = 1'b1;
        end else begin
            if (vert_cnt == 0) begin
                fan_pt = p;
            end else if (vert_cnt >= 2) begin
                mag = fan_cross_mag(p);
                if (pfa_pkg::AREA_W'(mag) > AREA_MAX - twice_area_sum) begin
                    twice_area_sum = AREA_MAX;
                    ovf_sticky = 1'b1;
                end else begin
                    twice_area_sum += pfa_pkg::AREA_W'(mag);
                end
            end
            prev_pt = p;
            vert_cnt++;
        end
        res = '0;
        if (!lst) return 1'b0;
        res.area  = (vert_cnt < 3) ? '0 : twice_area_sum;
        res.total = pfa_pkg::TOTAL_W'(vert_cnt);
        res.ovf   = ovf_sticky;
        clear_polygon();
        return 1'b1;
    endfunction

    initial clear_polygon();

    always @(posedge i_clk) begin
        t_area_result got, want;
        logic signed [pfa_pkg::COORD_W-1:0] p[3];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_area, o_vertex_total, o_overflow};
            if (area_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result area=%0d total=%0d ovf=%0b",
                             got.area, got.total, got.ovf);
            end else begin
                want = area_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp area=%0d total=%0d ovf=%0b, got area=%0d total=%0d ovf=%0b",
                                 want.area, want.total, want.ovf,
                                 got.area, got.total, got.ovf);
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            p = '{i_vx, i_vy, i_vz};
            if (add_vertex(p, i_last, want))
                area_q.push_back(req_typed ? req_res : want);
        end
    end

    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
        end else if (long_hold) begin
            i_stall <= 1'b1;
            repeat (400) @(posedge i_clk);
            long_hold = 1'b0;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            i_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    task automatic send(logic [pfa_pkg::COORD_W-1:0] x, y, z, logic lst,
                        bit typed = 1'b0, t_area_result res = '0);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_vx <= x; i_vy <= y; i_vz <= z; i_last <= lst;
        req_typed <= typed; req_res <= res;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic void add_row(int x, y, z, bit lst, bit typed = 0,
                                    longint ar = 0, int tot = 0, bit ov = 0);
        t_vertex_row r;
        r.x = pfa_pkg::COORD_W'(x); r.y = pfa_pkg::COORD_W'(y); r.z = pfa_pkg::COORD_W'(z);
        r.last = lst; r.typed = typed;
        r.res = '{pfa_pkg::AREA_W'(ar), pfa_pkg::TOTAL_W'(tot), ov};
        rows.push_back(r);
    endfunction

    function automatic logic [pfa_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return pfa_pkg::COORD_W'($urandom);
            1: return pfa_pkg::COORD_W'($urandom_range(0, 64)) - pfa_pkg::COORD_W'(32);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return pfa_pkg::COORD_W'($urandom_range(0, 2048))
                             - pfa_pkg::COORD_W'(1024);
        endcase
    endfunction

    initial begin
        int sent, len;
        bit held;
        held = 1'b0;
        // single and pair polygons give no area
        add_row(100, -200, 300, 1, 1, 0, 1, 0);
        add_row(-32768, 32767, 0, 0);
        add_row(32767, -32768, -1, 1, 1, 0, 2, 0);
        // unit right triangle in xy plane
        add_row(0, 0, 0, 0);
        add_row(16, 0, 0, 0);
        add_row(0, 16, 0, 1, 1, 256, 3, 0);
        // largest right triangle
        add_row(-32768, -32768, 0, 0);
        add_row(32767, -32768, 0, 0);
        add_row(-32768, 32767, 0, 1, 1, 64'd4294836225, 3, 0);
        // collinear extremes
        add_row(-32768, -32768, -32768, 0);
        add_row(0, 0, 0, 0);
        add_row(32767, 32767, 32767, 1, 1, 0, 3, 0);
        // skew quad with every coordinate sign
        add_row(-32768, 32767, -32768, 0);
        add_row(32767, 32767, 32767, 0);
        add_row(32767, -32768, -32768, 0);
        add_row(-5, -32768, 32767, 1);
        // tilted pentagon
        add_row(1, 2, 3, 0);
        add_row(400, -7, 90, 0);
        add_row(-300, 500, -20, 0);
        add_row(-1, -1, -1, 0);
        add_row(255, 255, -255, 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i])
            send(rows[i].x, rows[i].y, rows[i].z, rows[i].last, rows[i].typed, rows[i].res);

        sent = 0;
        while (sent < 500) begin
            if (sent > 440) quiet = 1'b1;
            if (sent >= 40 && !held) begin
                long_hold = 1'b1;
                held = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int v = 0; v < len; v++)
                send(rand_coord(), rand_coord(), rand_coord(), v == len - 1);
            sent += len;
            // one polygon past the vertex limit
            if (sent >= 200 && sent < 200 + len) begin
                for (int v = 0; v < MAX_VERTS + 4; v++)
                    send(rand_coord(), rand_coord(), rand_coord(), v == MAX_VERTS + 3);
                sent += MAX_VERTS + 4;
            end
        end
        i_valid <= 1'b0;
        while (area_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (mismatches == 0 && area_q.size() == 0)
            $display("** polygon_fan_area_accumulator: PASSED **");
        else
            $display("** polygon_fan_area_accumulator: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** polygon_fan_area_accumulator: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pfa_pkg.sv
hdl/pfa_mul.sv
hdl/pfa_isqrt.sv
hdl/polygon_fan_area_accumulator.sv
hdl/pfa_chk.sv
test/tb.sv
